[rtl/jsv_pkg.sv]
// shared types and constants of the json syntax validator
`default_nettype none

package jsv_pkg;

   // character classes handed from the classifier to the parser
   typedef enum logic [4:0] {
      CLS_SPACE,
      CLS_WSCTRL,
      CLS_CTRL,
      CLS_QUOTE,
      CLS_BSLASH,
      CLS_SLASH,
      CLS_LBRACE,
      CLS_RBRACE,
      CLS_LBRACK,
      CLS_RBRACK,
      CLS_COMMA,
      CLS_COLON,
      CLS_MINUS,
      CLS_PLUS,
      CLS_DOT,
      CLS_ZERO,
      CLS_DIGIT,
      CLS_A,
      CLS_B,
      CLS_E,
      CLS_F,
      CLS_HEX_LOWER,
      CLS_HEX_UPPER,
      CLS_UPPER_E,
      CLS_L,
      CLS_N,
      CLS_R,
      CLS_S,
      CLS_T,
      CLS_U,
      CLS_OTHER
   } cls_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_ACCEPT  = 2'd1,
      ST_REJECT  = 2'd2
   } status_type;

   typedef struct packed {
      cls_type cls;
      logic    last;
   } item_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[rtl/jsv_front.sv]
// byte classifier in front of the queue
`default_nettype none

module jsv_front (
   input  wire logic [7:0]        req_byte_in,
   input  wire logic              req_is_last,
   output jsv_pkg::item_type      item
);

   jsv_pkg::cls_type cls;

   always_comb begin
      cls = jsv_pkg::CLS_OTHER;
      if (req_byte_in == 8'h20) begin
         cls = jsv_pkg::CLS_SPACE;
      end else if (req_byte_in >= 8'h09 && req_byte_in <= 8'h0D) begin
         cls = jsv_pkg::CLS_WSCTRL;
      end else if (req_byte_in < 8'h20) begin
         cls = jsv_pkg::CLS_CTRL;
      end else if (req_byte_in >= 8'h31 && req_byte_in <= 8'h39) begin
         cls = jsv_pkg::CLS_DIGIT;
      end else begin
         unique case (req_byte_in)
            8'h22:                      cls = jsv_pkg::CLS_QUOTE;
            8'h5C:                      cls = jsv_pkg::CLS_BSLASH;
            8'h2F:                      cls = jsv_pkg::CLS_SLASH;
            8'h7B:                      cls = jsv_pkg::CLS_LBRACE;
            8'h7D:                      cls = jsv_pkg::CLS_RBRACE;
            8'h5B:                      cls = jsv_pkg::CLS_LBRACK;
            8'h5D:                      cls = jsv_pkg::CLS_RBRACK;
            8'h2C:                      cls = jsv_pkg::CLS_COMMA;
            8'h3A:                      cls = jsv_pkg::CLS_COLON;
            8'h2D:                      cls = jsv_pkg::CLS_MINUS;
            8'h2B:                      cls = jsv_pkg::CLS_PLUS;
            8'h2E:                      cls = jsv_pkg::CLS_DOT;
            8'h30:                      cls = jsv_pkg::CLS_ZERO;
            8'h61:                      cls = jsv_pkg::CLS_A;
            8'h62:                      cls = jsv_pkg::CLS_B;
            8'h65:                      cls = jsv_pkg::CLS_E;
            8'h66:                      cls = jsv_pkg::CLS_F;
            8'h63, 8'h64:               cls = jsv_pkg::CLS_HEX_LOWER;
            8'h41, 8'h42, 8'h43, 8'h44,
            8'h46:                      cls = jsv_pkg::CLS_HEX_UPPER;
            8'h45:                      cls = jsv_pkg::CLS_UPPER_E;
            8'h6C:                      cls = jsv_pkg::CLS_L;
            8'h6E:                      cls = jsv_pkg::CLS_N;
            8'h72:                      cls = jsv_pkg::CLS_R;
            8'h73:                      cls = jsv_pkg::CLS_S;
            8'h74:                      cls = jsv_pkg::CLS_T;
            8'h75:                      cls = jsv_pkg::CLS_U;
            default:                    cls = jsv_pkg::CLS_OTHER;
         endcase
      end
   end

   assign item.cls  = cls;
   assign item.last = req_is_last;

endmodule

`default_nettype wire

[rtl/jsv_queue.sv]
// short fifo of classified bytes between classifier and parser
`default_nettype none

module jsv_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire jsv_pkg::item_type push_item,
   input  wire logic              pop,
   output jsv_pkg::item_type      head_item,
   output logic                   head_valid,
   output logic                   full
);

   localparam int PTR_W = (jsv_pkg::QUEUE_DEPTH > 1) ? $clog2(jsv_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(jsv_pkg::QUEUE_DEPTH + 1);

   jsv_pkg::item_type entry_ff [jsv_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(jsv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(jsv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(jsv_pkg::QUEUE_DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not follow a read");

endmodule

`default_nettype wire

[rtl/jsv_back.sv]
// grammar state machine, container stack and result register
`default_nettype none

module jsv_back #(
   parameter int MAX_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire jsv_pkg::item_type head_item,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_open_count
);

   localparam int KIND_SLOTS = MAX_DEPTH + 1;
   localparam int LVL_W      = $clog2(MAX_DEPTH + 2);

   localparam logic       KIND_OBJECT = 1'b1;
   localparam logic       KIND_ARRAY  = 1'b0;
   localparam logic [1:0] LIT_TRUE    = 2'd0;
   localparam logic [1:0] LIT_FALSE   = 2'd1;
   localparam logic [1:0] LIT_NULL    = 2'd2;

   typedef enum logic [4:0] {
      PH_VALUE,
      PH_ARR_FIRST,
      PH_OBJ_FIRST,
      PH_KEY,
      PH_COLON,
      PH_AFTER,
      PH_STR,
      PH_ESC,
      PH_HEX,
      PH_KSTR,
      PH_KESC,
      PH_KHEX,
      PH_MINUS,
      PH_ZERO,
      PH_INT,
      PH_DOT,
      PH_FRAC,
      PH_E,
      PH_ESIGN,
      PH_EXP,
      PH_LIT
   } phase_type;

   // expected character of a literal at a position
   function automatic logic lit_hit(logic [1:0] kind, logic [2:0] pos, jsv_pkg::cls_type c);
      logic hit;
      hit = 1'b0;
      unique case (kind)
         LIT_TRUE: begin
            unique case (pos)
               3'd1:    hit = (c == jsv_pkg::CLS_R);
               3'd2:    hit = (c == jsv_pkg::CLS_U);
               3'd3:    hit = (c == jsv_pkg::CLS_E);
               default: hit = 1'b0;
            endcase
         end
         LIT_FALSE: begin
            unique case (pos)
               3'd1:    hit = (c == jsv_pkg::CLS_A);
               3'd2:    hit = (c == jsv_pkg::CLS_L);
               3'd3:    hit = (c == jsv_pkg::CLS_S);
               3'd4:    hit = (c == jsv_pkg::CLS_E);
               default: hit = 1'b0;
            endcase
         end
         LIT_NULL: begin
            unique case (pos)
               3'd1:    hit = (c == jsv_pkg::CLS_U);
               3'd2:    hit = (c == jsv_pkg::CLS_L);
               3'd3:    hit = (c == jsv_pkg::CLS_L);
               default: hit = 1'b0;
            endcase
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   phase_type              phase_ff, phase_in;
   logic [KIND_SLOTS-1:0]  kinds_ff, kinds_in;
   logic [LVL_W-1:0]       level_ff, level_in;
   logic [2:0]             sub_ff, sub_in;
   logic [1:0]             lit_ff, lit_in;
   logic                   rejected_ff, rejected_in;
   logic                   rsp_valid_ff;
   jsv_pkg::status_type    rsp_status_ff, status_in;
   logic [3:0]             rsp_open_ff;
   logic [LVL_W+3:0]       level_wide;

   jsv_pkg::cls_type c;
   logic is_ws, is_dig, is_hex, is_esc, is_exp, is_bad_str;
   logic start_now, after_now, close_now, done;
   logic [2:0] sub_inc;
   logic [2:0] lit_len;

   assign c          = head_item.cls;
   assign is_ws      = (c == jsv_pkg::CLS_SPACE) || (c == jsv_pkg::CLS_WSCTRL);
   assign is_dig     = (c == jsv_pkg::CLS_ZERO) || (c == jsv_pkg::CLS_DIGIT);
   assign is_exp     = (c == jsv_pkg::CLS_E) || (c == jsv_pkg::CLS_UPPER_E);
   assign is_hex     = is_dig || is_exp || (c == jsv_pkg::CLS_A) || (c == jsv_pkg::CLS_B) ||
                       (c == jsv_pkg::CLS_F) || (c == jsv_pkg::CLS_HEX_LOWER) ||
                       (c == jsv_pkg::CLS_HEX_UPPER);
   assign is_esc     = (c == jsv_pkg::CLS_QUOTE) || (c == jsv_pkg::CLS_BSLASH) ||
                       (c == jsv_pkg::CLS_SLASH) || (c == jsv_pkg::CLS_B) ||
                       (c == jsv_pkg::CLS_F) || (c == jsv_pkg::CLS_N) ||
                       (c == jsv_pkg::CLS_R) || (c == jsv_pkg::CLS_T);
   assign is_bad_str = (c == jsv_pkg::CLS_WSCTRL) || (c == jsv_pkg::CLS_CTRL);
   assign sub_inc    = sub_ff + 3'd1;
   assign lit_len    = (lit_ff == LIT_FALSE) ? 3'd5 : 3'd4;

   always_comb begin
      phase_in    = phase_ff;
      kinds_in    = kinds_ff;
      level_in    = level_ff;
      sub_in      = sub_ff;
      lit_in      = lit_ff;
      rejected_in = rejected_ff;
      start_now   = 1'b0;
      after_now   = 1'b0;
      close_now   = 1'b0;

      if (!rejected_ff) begin
         unique case (phase_ff)
            PH_VALUE: begin
               if (!is_ws) start_now = 1'b1;
            end
            PH_ARR_FIRST: begin
               if (!is_ws) begin
                  if (c == jsv_pkg::CLS_RBRACK) close_now = 1'b1;
                  else start_now = 1'b1;
               end
            end
            PH_OBJ_FIRST: begin
               if (!is_ws) begin
                  if (c == jsv_pkg::CLS_RBRACE) close_now = 1'b1;
                  else if (c == jsv_pkg::CLS_QUOTE) phase_in = PH_KSTR;
                  else rejected_in = 1'b1;
               end
            end
            PH_KEY: begin
               if (!is_ws) begin
                  if (c == jsv_pkg::CLS_QUOTE) phase_in = PH_KSTR;
                  else rejected_in = 1'b1;
               end
            end
            PH_COLON: begin
               if (!is_ws) begin
                  if (c == jsv_pkg::CLS_COLON) phase_in = PH_VALUE;
                  else rejected_in = 1'b1;
               end
            end
            PH_AFTER: after_now = 1'b1;
            PH_STR, PH_KSTR: begin
               if (c == jsv_pkg::CLS_QUOTE) begin
                  phase_in = (phase_ff == PH_KSTR) ? PH_COLON : PH_AFTER;
               end else if (is_bad_str) begin
                  rejected_in = 1'b1;
               end else if (c == jsv_pkg::CLS_BSLASH) begin
                  phase_in = (phase_ff == PH_KSTR) ? PH_KESC : PH_ESC;
               end
            end
            PH_ESC, PH_KESC: begin
               if (is_esc) begin
                  phase_in = (phase_ff == PH_KESC) ? PH_KSTR : PH_STR;
               end else if (c == jsv_pkg::CLS_U) begin
                  sub_in   = '0;
                  phase_in = (phase_ff == PH_KESC) ? PH_KHEX : PH_HEX;
               end else begin
                  rejected_in = 1'b1;
               end
            end
            PH_HEX, PH_KHEX: begin
               if (!is_hex) begin
                  rejected_in = 1'b1;
               end else if (sub_inc >= 3'd4) begin
                  sub_in   = '0;
                  phase_in = (phase_ff == PH_KHEX) ? PH_KSTR : PH_STR;
               end else begin
                  sub_in = sub_inc;
               end
            end
            PH_MINUS: begin
               if (c == jsv_pkg::CLS_ZERO) phase_in = PH_ZERO;
               else if (c == jsv_pkg::CLS_DIGIT) phase_in = PH_INT;
               else rejected_in = 1'b1;
            end
            PH_ZERO: begin
               if (c == jsv_pkg::CLS_DOT) phase_in = PH_DOT;
               else if (is_exp) phase_in = PH_E;
               else after_now = 1'b1;
            end
            PH_INT: begin
               if (is_dig) phase_in = PH_INT;
               else if (c == jsv_pkg::CLS_DOT) phase_in = PH_DOT;
               else if (is_exp) phase_in = PH_E;
               else after_now = 1'b1;
            end
            PH_DOT: begin
               if (is_dig) phase_in = PH_FRAC;
               else rejected_in = 1'b1;
            end
            PH_FRAC: begin
               if (is_dig) phase_in = PH_FRAC;
               else if (is_exp) phase_in = PH_E;
               else after_now = 1'b1;
            end
            PH_E: begin
               if (c == jsv_pkg::CLS_PLUS || c == jsv_pkg::CLS_MINUS) phase_in = PH_ESIGN;
               else if (is_dig) phase_in = PH_EXP;
               else rejected_in = 1'b1;
            end
            PH_ESIGN: begin
               if (is_dig) phase_in = PH_EXP;
               else rejected_in = 1'b1;
            end
            PH_EXP: begin
               if (!is_dig) after_now = 1'b1;
            end
            PH_LIT: begin
               if (lit_hit(lit_ff, sub_ff, c)) begin
                  if (sub_inc >= lit_len) begin
                     sub_in   = '0;
                     phase_in = PH_AFTER;
                  end else begin
                     sub_in = sub_inc;
                  end
               end else begin
                  rejected_in = 1'b1;
               end
            end
            default: rejected_in = 1'b1;
         endcase

         // first byte of a value
         if (start_now) begin
            if (level_ff > LVL_W'(MAX_DEPTH)) begin
               rejected_in = 1'b1;
            end else if (c == jsv_pkg::CLS_QUOTE) begin
               phase_in = PH_STR;
            end else if (c == jsv_pkg::CLS_LBRACE) begin
               kinds_in = {kinds_ff[KIND_SLOTS-2:0], KIND_OBJECT};
               level_in = level_ff + 1'b1;
               phase_in = PH_OBJ_FIRST;
            end else if (c == jsv_pkg::CLS_LBRACK) begin
               kinds_in = {kinds_ff[KIND_SLOTS-2:0], KIND_ARRAY};
               level_in = level_ff + 1'b1;
               phase_in = PH_ARR_FIRST;
            end else if (c == jsv_pkg::CLS_T) begin
               lit_in   = LIT_TRUE;
               sub_in   = 3'd1;
               phase_in = PH_LIT;
            end else if (c == jsv_pkg::CLS_F) begin
               lit_in   = LIT_FALSE;
               sub_in   = 3'd1;
               phase_in = PH_LIT;
            end else if (c == jsv_pkg::CLS_N) begin
               lit_in   = LIT_NULL;
               sub_in   = 3'd1;
               phase_in = PH_LIT;
            end else if (c == jsv_pkg::CLS_MINUS) begin
               phase_in = PH_MINUS;
            end else if (c == jsv_pkg::CLS_ZERO) begin
               phase_in = PH_ZERO;
            end else if (c == jsv_pkg::CLS_DIGIT) begin
               phase_in = PH_INT;
            end else begin
               rejected_in = 1'b1;
            end
         end

         // byte after a finished value, also the byte that ends a number
         if (after_now) begin
            phase_in = PH_AFTER;
            if (!is_ws) begin
               if (level_ff == '0) begin
                  rejected_in = 1'b1;
               end else if (c == jsv_pkg::CLS_COMMA) begin
                  phase_in = (kinds_ff[0] == KIND_OBJECT) ? PH_KEY : PH_VALUE;
               end else if ((kinds_ff[0] == KIND_OBJECT && c == jsv_pkg::CLS_RBRACE) ||
                            (kinds_ff[0] == KIND_ARRAY && c == jsv_pkg::CLS_RBRACK)) begin
                  close_now = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end
         end

         if (close_now) begin
            kinds_in = {1'b0, kinds_ff[KIND_SLOTS-1:1]};
            level_in = level_ff - 1'b1;
            phase_in = PH_AFTER;
         end
      end

      done = (level_in == '0) &&
             (phase_in == PH_AFTER || phase_in == PH_ZERO || phase_in == PH_INT ||
              phase_in == PH_FRAC || phase_in == PH_EXP);

      if (rejected_in) status_in = jsv_pkg::ST_REJECT;
      else if (head_item.last) status_in = done ? jsv_pkg::ST_ACCEPT : jsv_pkg::ST_REJECT;
      else status_in = jsv_pkg::ST_PENDING;
   end

   assign level_wide = (LVL_W+4)'(level_in);
   assign pop        = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VALUE;
         kinds_ff     <= '0;
         level_ff     <= '0;
         sub_ff       <= '0;
         lit_ff       <= LIT_TRUE;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (head_item.last) begin
               phase_ff    <= PH_VALUE;
               kinds_ff    <= '0;
               level_ff    <= '0;
               sub_ff      <= '0;
               lit_ff      <= LIT_TRUE;
               rejected_ff <= 1'b0;
            end else begin
               phase_ff    <= phase_in;
               kinds_ff    <= kinds_in;
               level_ff    <= level_in;
               sub_ff      <= sub_in;
               lit_ff      <= lit_in;
               rejected_ff <= rejected_in;
            end
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_in;
            rsp_open_ff   <= level_wide[3:0];
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_open_count = rsp_open_ff;

   a_accept_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == jsv_pkg::ST_ACCEPT |-> rsp_open_ff == '0)
      else $error("document accepted with containers open");

   a_reject_sticks: assert property (@(posedge clock) disable iff (reset)
      pop && rejected_ff && !head_item.last |=> rejected_ff)
      else $error("rejection dropped before the last byte");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      pop && head_item.last |=> phase_ff == PH_VALUE && level_ff == '0 && !rejected_ff)
      else $error("parser not restarted after the last byte");

endmodule

`default_nettype wire

[rtl/json_syntax_validator_top.sv]
// top level of the byte-serial json syntax validator
// a byte is stored in a queue entry, then its status beat is registered in the parser
// throughput: one byte per cycle unless output stalls; parser state updates once per byte
// a two-entry queue between classifier and parser lets input and output stall apart
// reset is synchronous: queue, parser state, container stack and output valid clear at once
// no clearing pass after reset; the first byte may follow the edge that drops reset
`default_nettype none

module json_syntax_validator_top #(
   parameter int MAX_DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // byte input channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_is_last,
   // status output channel, one beat per byte
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [3:0]      rsp_open_count
);

   // front: byte to character class
   jsv_pkg::item_type front_item;
   // queue head towards the parser
   jsv_pkg::item_type head_item;
   logic              head_valid;
   logic              queue_full;
   logic              push;
   logic              pop;

   jsv_front u_front (
      .req_byte_in (req_byte_in),
      .req_is_last (req_is_last),
      .item        (front_item)
   );

   // stall only on a full queue, so a waiting result never blocks intake
   // while a slot is free
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   jsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // back: grammar walk, container stack and registered status beat
   jsv_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_open_count (rsp_open_count)
   );

endmodule

`default_nettype wire

[tb/sv/json_syntax_validator_top_test.sv]
// self-checking testbench of the json syntax validator: random documents in, status beats checked
module json_syntax_validator_top_test;

   localparam int MAX_DEPTH     = 8;
   localparam int SLOTS         = MAX_DEPTH + 1;   // containers that may be open at once
   localparam int TOTAL_ITEMS   = 650;
   localparam int LONG_HOLD     = 60;              // receiver hold-off long enough to back up the input
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;               // margin for the queue and status registers to empty

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   // where the parser stands inside the document
   typedef enum logic [4:0] {
      SEEK_VALUE,
      ARR_OPEN,
      OBJ_OPEN,
      SEEK_KEY,
      SEEK_COLON,
      VALUE_DONE,
      IN_STR,
      STR_ESC,
      STR_HEX,
      IN_KEY,
      KEY_ESC,
      KEY_HEX,
      NUM_SIGN,
      NUM_ZERO,
      NUM_INT,
      NUM_DOT,
      NUM_FRAC,
      NUM_EXP_MARK,
      NUM_EXP_SIGN,
      NUM_EXP,
      IN_LIT
   } parse_phase_type;

   // one byte waiting to be sent, with pacing hints
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;   // hold this byte until every owed status beat is back
      logic       tight;   // no gaps inside this document
   } doc_byte_type;

   typedef struct packed {
      jsv_pkg::status_type status;
      logic [3:0]          open_count;
   } status_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_open_count;

   json_syntax_validator_top #(
      .MAX_DEPTH(MAX_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_in(req_byte_in),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_open_count(rsp_open_count)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // syntax tracker: own copy of the parser state
   // ---------------------------------------------------------------
   parse_phase_type parse_at;
   logic            kind_stack [SLOTS];   // 1 object, 0 array
   logic [3:0]      depth_now;
   logic [2:0]      sub_count;            // hex digits seen, or position in a literal
   logic [1:0]      lit_sel;
   logic            doc_bad;

   // run statistics for the summary
   int docs_accepted = 0;
   int docs_rejected = 0;
   int deepest = 0;
   int depth_rejects = 0;

   doc_byte_type    pending_bytes [$];
   status_beat_type beats_owed [$];
   logic [7:0]      doc_bytes [$];

   int fail_count = 0;
   int results_seen = 0;
   int item_total = 0;
   int docs_built = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int run_left = 0;
   int next_hold_at = 120;
   logic byte_sent = 1'b0;

   function automatic void reset_parser();
      parse_at = SEEK_VALUE;
      foreach (kind_stack[i]) kind_stack[i] = 1'b0;
      depth_now = '0;
      sub_count = '0;
      lit_sel = LIT_TRUE;
      doc_bad = 1'b0;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_simple_escape(input logic [7:0] c);
      return c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" || c == "f" ||
             c == "n" || c == "r" || c == "t";
   endfunction

   function automatic int lit_len(input logic [1:0] sel);
      return (sel == LIT_FALSE) ? 5 : 4;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
      logic [39:0] word;
      case (sel)
         LIT_TRUE: word = "true";
         LIT_FALSE: word = "false";
         default: word = "null";
      endcase
      return word[8 * (lit_len(sel) - 1 - int'(pos)) +: 8];
   endfunction

   function automatic void open_box(input logic kind, input parse_phase_type next);
      if (depth_now >= SLOTS) begin
         doc_bad = 1'b1;
      end else begin
         kind_stack[depth_now] = kind;
         depth_now = depth_now + 1'b1;
         parse_at = next;
      end
   endfunction

   function automatic void close_box();
      if (depth_now > 0) depth_now = depth_now - 1'b1;
      parse_at = VALUE_DONE;
   endfunction

   // first non-blank byte of a value; refused outright with every slot in use
   function automatic void begin_value(input logic [7:0] c);
      if (depth_now > MAX_DEPTH) begin
         doc_bad = 1'b1;
         depth_rejects++;
      end else if (c == CH_QUOTE) begin
         parse_at = IN_STR;
      end else if (c == "{") begin
         open_box(1'b1, OBJ_OPEN);
      end else if (c == "[") begin
         open_box(1'b0, ARR_OPEN);
      end else if (c == "t" || c == "f" || c == "n") begin
         lit_sel = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
         sub_count = 3'd1;
         parse_at = IN_LIT;
      end else if (c == "-") begin
         parse_at = NUM_SIGN;
      end else if (c == "0") begin
         parse_at = NUM_ZERO;
      end else if (is_digit(c)) begin
         parse_at = NUM_INT;
      end else begin
         doc_bad = 1'b1;
      end
   endfunction

   // byte after a finished value: separator or closer of the innermost container
   function automatic void after_val(input logic [7:0] c);
      logic top;
      if (!is_space(c)) begin
         if (depth_now == 0) begin
            doc_bad = 1'b1;
         end else begin
            top = kind_stack[depth_now - 1'b1];
            if (c == ",") parse_at = top ? SEEK_KEY : SEEK_VALUE;
            else if (c == (top ? "}" : "]")) close_box();
            else doc_bad = 1'b1;
         end
      end
   endfunction

   function automatic void string_step(input logic [7:0] c, input logic key);
      if (parse_at == IN_STR || parse_at == IN_KEY) begin
         if (c == CH_QUOTE) parse_at = key ? SEEK_COLON : VALUE_DONE;
         else if (c < 8'h20) doc_bad = 1'b1;
         else if (c == CH_BSLASH) parse_at = key ? KEY_ESC : STR_ESC;
      end else if (parse_at == STR_ESC || parse_at == KEY_ESC) begin
         if (is_simple_escape(c)) begin
            parse_at = key ? IN_KEY : IN_STR;
         end else if (c == "u") begin
            sub_count = '0;
            parse_at = key ? KEY_HEX : STR_HEX;
         end else begin
            doc_bad = 1'b1;
         end
      end else if (!is_hex(c)) begin
         doc_bad = 1'b1;
      end else begin
         sub_count = sub_count + 1'b1;
         if (sub_count >= 4) begin
            sub_count = '0;
            parse_at = key ? IN_KEY : IN_STR;
         end
      end
   endfunction

   // advance the tracker by one byte and give the status beat it owes
   function automatic status_beat_type judge_byte(input logic [7:0] c, input logic last);
      status_beat_type beat;
      logic            extended;
      logic            finished;
      if (!doc_bad) begin
         extended = 1'b1;
         case (parse_at)
            NUM_SIGN: begin
               if (c == "0") parse_at = NUM_ZERO;
               else if (is_digit(c)) parse_at = NUM_INT;
               else doc_bad = 1'b1;
            end
            NUM_ZERO, NUM_INT: begin
               if (!(parse_at == NUM_INT && is_digit(c))) begin
                  if (c == ".") parse_at = NUM_DOT;
                  else if (c == "e" || c == "E") parse_at = NUM_EXP_MARK;
                  else extended = 1'b0;
               end
            end
            NUM_DOT: begin
               if (is_digit(c)) parse_at = NUM_FRAC;
               else doc_bad = 1'b1;
            end
            NUM_FRAC: begin
               if (!is_digit(c)) begin
                  if (c == "e" || c == "E") parse_at = NUM_EXP_MARK;
                  else extended = 1'b0;
               end
            end
            NUM_EXP_MARK: begin
               if (c == "+" || c == "-") parse_at = NUM_EXP_SIGN;
               else if (is_digit(c)) parse_at = NUM_EXP;
               else doc_bad = 1'b1;
            end
            NUM_EXP_SIGN: begin
               if (is_digit(c)) parse_at = NUM_EXP;
               else doc_bad = 1'b1;
            end
            NUM_EXP: begin
               if (!is_digit(c)) extended = 1'b0;
            end
            SEEK_VALUE: begin
               if (!is_space(c)) begin_value(c);
            end
            ARR_OPEN: begin
               if (!is_space(c)) begin
                  if (c == "]") close_box();
                  else begin_value(c);
               end
            end
            OBJ_OPEN: begin
               if (!is_space(c)) begin
                  if (c == "}") close_box();
                  else if (c == CH_QUOTE) parse_at = IN_KEY;
                  else doc_bad = 1'b1;
               end
            end
            SEEK_KEY: begin
               if (!is_space(c)) begin
                  if (c == CH_QUOTE) parse_at = IN_KEY;
                  else doc_bad = 1'b1;
               end
            end
            SEEK_COLON: begin
               if (!is_space(c)) begin
                  if (c == ":") parse_at = SEEK_VALUE;
                  else doc_bad = 1'b1;
               end
            end
            VALUE_DONE: after_val(c);
            IN_STR, STR_ESC, STR_HEX: string_step(c, 1'b0);
            IN_KEY, KEY_ESC, KEY_HEX: string_step(c, 1'b1);
            IN_LIT: begin
               if (sub_count < lit_len(lit_sel) && c == lit_char(lit_sel, sub_count)) begin
                  sub_count = sub_count + 1'b1;
                  if (sub_count >= lit_len(lit_sel)) begin
                     sub_count = '0;
                     parse_at = VALUE_DONE;
                  end
               end else begin
                  doc_bad = 1'b1;
               end
            end
            default: doc_bad = 1'b1;
         endcase
         // a number that cannot grow is over; the byte is then seen after the value
         if (!extended) begin
            parse_at = VALUE_DONE;
            after_val(c);
         end
      end

      finished = depth_now == 0 &&
                 (parse_at == VALUE_DONE || parse_at == NUM_ZERO || parse_at == NUM_INT ||
                  parse_at == NUM_FRAC || parse_at == NUM_EXP);
      if (doc_bad) beat.status = jsv_pkg::ST_REJECT;
      else if (last) beat.status = finished ? jsv_pkg::ST_ACCEPT : jsv_pkg::ST_REJECT;
      else beat.status = jsv_pkg::ST_PENDING;
      beat.open_count = depth_now;

      if (int'(depth_now) > deepest) deepest = depth_now;
      if (last) begin
         if (beat.status == jsv_pkg::ST_ACCEPT) docs_accepted++;
         else docs_rejected++;
         reset_parser();
      end
      return beat;
   endfunction

   // ---------------------------------------------------------------
   // document builder
   // ---------------------------------------------------------------
   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endfunction

   function automatic void gen_ws();
      int n;
      n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      repeat (n) begin
         if ($urandom_range(0, 1) == 0) doc_bytes.push_back(8'h20);
         else doc_bytes.push_back(8'(8'h09 + $urandom_range(0, 4)));
      end
   endfunction

   function automatic void gen_digits(input int n);
      repeat (n) doc_bytes.push_back(8'("0" + $urandom_range(0, 9)));
   endfunction

   function automatic void gen_string();
      int         n;
      int         pick;
      logic [7:0] ch;
      doc_bytes.push_back(CH_QUOTE);
      n = $urandom_range(0, 3);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
            if (ch == CH_QUOTE || ch == CH_BSLASH) ch = "x";
            doc_bytes.push_back(ch);
         end else if (pick < 78) begin
            // high bytes are plain characters inside strings
            doc_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
         end else if (pick < 92) begin
            doc_bytes.push_back(CH_BSLASH);
            case ($urandom_range(0, 7))
               0: ch = CH_QUOTE;
               1: ch = CH_BSLASH;
               2: ch = "/";
               3: ch = "b";
               4: ch = "f";
               5: ch = "n";
               6: ch = "r";
               default: ch = "t";
            endcase
            doc_bytes.push_back(ch);
         end else begin
            add_text("\\u");
            repeat (4) begin
               case ($urandom_range(0, 2))
                  0: ch = 8'("0" + $urandom_range(0, 9));
                  1: ch = 8'("a" + $urandom_range(0, 5));
                  default: ch = 8'("A" + $urandom_range(0, 5));
               endcase
               doc_bytes.push_back(ch);
            end
         end
      end
      doc_bytes.push_back(CH_QUOTE);
   endfunction

   function automatic void gen_number();
      if ($urandom_range(0, 2) == 0) add_text("-");
      if ($urandom_range(0, 3) == 0) begin
         add_text("0");
      end else begin
         doc_bytes.push_back(8'("1" + $urandom_range(0, 8)));
         gen_digits($urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) begin
         add_text(".");
         gen_digits($urandom_range(1, 2));
      end
      if ($urandom_range(0, 3) == 0) begin
         doc_bytes.push_back($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: add_text("+");
            1: add_text("-");
            default: ;
         endcase
         gen_digits($urandom_range(1, 2));
      end
   endfunction

   // a well-formed value; a dive keeps nesting down to the last slot
   function automatic void gen_value(input int lvl, input logic dive);
      int   pick;
      int   n;
      logic inner_dive;
      pick = dive ? ($urandom_range(0, 1) ? 5 : 8) : $urandom_range(0, 9);
      inner_dive = 1'b0;
      n = 0;
      if (pick >= 5) begin
         if (dive && lvl + 1 < SLOTS) begin
            n = 1;
            inner_dive = 1'b1;
         end else if (dive) begin
            // innermost slot: mostly empty, sometimes a value that hits the limit
            n = ($urandom_range(0, 3) == 0) ? 1 : 0;
         end else begin
            n = (lvl < 2) ? $urandom_range(0, 3) : $urandom_range(0, 1);
         end
      end
      case (pick)
         0, 1: gen_string();
         2: begin
            case ($urandom_range(0, 2))
               0: add_text("true");
               1: add_text("false");
               default: add_text("null");
            endcase
         end
         3, 4: gen_number();
         5, 6, 7: begin
            add_text("[");
            for (int i = 0; i < n; i++) begin
               if (i > 0) add_text(",");
               gen_ws();
               gen_value(lvl + 1, inner_dive);
               gen_ws();
            end
            add_text("]");
         end
         default: begin
            add_text("{");
            for (int i = 0; i < n; i++) begin
               if (i > 0) add_text(",");
               gen_ws();
               gen_string();
               gen_ws();
               add_text(":");
               gen_ws();
               gen_value(lvl + 1, inner_dive);
               gen_ws();
            end
            add_text("}");
         end
      endcase
   endfunction

   // move the built document to the send queue, final byte flagged
   function automatic void flush_doc(input logic drain, input logic tight);
      doc_byte_type b;
      foreach (doc_bytes[i]) begin
         b.data = doc_bytes[i];
         b.last = (i == doc_bytes.size() - 1);
         b.drain = drain && (i == 0);
         b.tight = tight;
         pending_bytes.push_back(b);
      end
      item_total += doc_bytes.size();
      docs_built++;
      doc_bytes.delete();
   endfunction

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      int form;
      int idx;
      int n;
      reset_parser();

      // directed: all-ones and all-zeros bytes as whole documents
      doc_bytes.push_back(8'hFF);
      flush_doc(1'b0, 1'b0);
      doc_bytes.push_back(8'h00);
      flush_doc(1'b0, 1'b0);
      // high bytes inside a string
      add_text("\"");
      doc_bytes.push_back(8'h80);
      doc_bytes.push_back(8'hFF);
      add_text("\"");
      flush_doc(1'b0, 1'b0);
      // number closed by the bracket that ends it
      add_text("[-0.5E+1]");
      flush_doc(1'b0, 1'b1);
      // one bracket too many hits the depth limit, the closer after it is ignored
      add_text("[[[[[[[[[[]");
      flush_doc(1'b1, 1'b1);

      // random documents: mostly well formed, some damaged, a few pure noise
      while (item_total < TOTAL_ITEMS) begin
         form = $urandom_range(0, 99);
         if (form < 6) begin
            n = $urandom_range(1, 6);
            repeat (n) doc_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            gen_ws();
            gen_value(0, form < 20);
            gen_ws();
            if (form >= 72) begin
               idx = $urandom_range(0, doc_bytes.size() - 1);
               case ($urandom_range(0, 3))
                  0: doc_bytes[idx] = 8'($urandom_range(0, 255));
                  1: while (doc_bytes.size() > idx + 1) void'(doc_bytes.pop_back());
                  2: doc_bytes.insert(idx, 8'($urandom_range(0, 255)));
                  default: gen_value(0, 1'b0);
               endcase
            end
         end
         flush_doc(docs_built % 16 == 5, $urandom_range(0, 3) == 0);
      end

      // synchronous reset held, then dropped on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything sent and every owed beat back
      while (pending_bytes.size() != 0 || req_valid || beats_owed.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d documents: %0d accepted, %0d rejected",
               item_total, docs_built, docs_accepted, docs_rejected);
      $display("deepest nesting %0d of %0d slots, %0d refusals at the depth limit",
               deepest, SLOTS, depth_rejects);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // sender: one byte per beat, random gaps, drain points
   // ---------------------------------------------------------------
   always @(negedge clock) begin : byte_feed
      doc_byte_type next_byte;
      int           pick;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_sent) begin
         // the offered byte went through, or nothing was offered
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_bytes.size() != 0 &&
                      !(pending_bytes[0].drain && beats_owed.size() != 0)) begin
            next_byte = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_byte_in <= next_byte.data;
            req_is_last <= next_byte.last;
            pick = $urandom_range(0, 99);
            if (next_byte.tight || pick < 60) gap_left <= 0;
            else if (pick < 88) gap_left <= $urandom_range(1, 3);
            else if (pick < 97) gap_left <= $urandom_range(4, 12);
            else gap_left <= $urandom_range(20, 50);
         end else begin
            // out of bytes, or waiting for the pipeline to drain
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stall runs, plus a long hold every few hundred beats
   // ---------------------------------------------------------------
   always @(negedge clock) begin : rsp_pace
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
      end else if (results_seen >= next_hold_at) begin
         // long hold so the block fills and stalls the sender
         rsp_stall <= 1'b1;
         run_left <= LONG_HOLD;
         next_hold_at <= next_hold_at + 300;
      end else begin
         pick = $urandom_range(0, 99);
         rsp_stall <= (pick >= 60);
         run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      end
   end

   // ---------------------------------------------------------------
   // scoreboard: check the status beat first, then record the accepted byte
   // ---------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      status_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (beats_owed.size() == 0) begin
            $display("%0t: status beat with nothing owed: expected none, actual status %0d open %0d",
                     $time, rsp_status, rsp_open_count);
            fail_count++;
         end else begin
            want = beats_owed.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_open_count !== want.open_count) begin
               $display("%0t: open_count mismatch: expected %0d, actual %0d",
                        $time, want.open_count, rsp_open_count);
               fail_count++;
            end
         end
      end
      byte_sent <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         beats_owed.push_back(judge_byte(req_byte_in, req_is_last));
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d status beats still owed",
                  $time, beats_owed.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule
